### hdl/i2ssc_pkg.sv
`default_nettype none

package i2ssc_pkg;

  // Width of the binary input and of the decimal result of the conversion.
  localparam int unsigned NumW      = 32;
  localparam int unsigned BcdDigits = 10;
  localparam int unsigned BcdW      = 4 * BcdDigits;
  localparam int unsigned BcdIdxW   = $clog2(BcdDigits);

  // Kinds of controller writes.
  localparam logic WK_SCAN  = 1'b0;
  localparam logic WK_DIGIT = 1'b1;

  // Error run: scan limit and segment codes for "1", "r" and "E".
  localparam logic [2:0] ERR_LIMIT = 3'd3;
  localparam logic [2:0] ERR_POS_ONE = 3'd0;
  localparam logic [2:0] ERR_POS_R0  = 3'd1;
  localparam logic [2:0] ERR_POS_R1  = 3'd2;
  localparam logic [7:0] SEG_ONE = 8'h30;
  localparam logic [7:0] SEG_R   = 8'h05;
  localparam logic [7:0] SEG_E   = 8'h4F;

  // Seven-segment code of a decimal digit, bit 6 = a down to bit 0 = g.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h7E;
      4'd1:    code = 8'h30;
      4'd2:    code = 8'h6D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h33;
      4'd5:    code = 8'h5B;
      4'd6:    code = 8'h5F;
      4'd7:    code = 8'h70;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Segment code at a position of the error run.
  function automatic logic [7:0] err_code(input logic [2:0] pos);
    logic [7:0] code;
    case (pos)
      ERR_POS_ONE: code = SEG_ONE;
      ERR_POS_R0:  code = SEG_R;
      ERR_POS_R1:  code = SEG_R;
      default:     code = SEG_E;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### hdl/i2ssc_bcd.sv
`default_nettype none

// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
module i2ssc_bcd (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [i2ssc_pkg::NumW-1:0] number_i,
  output logic                           done_o,
  output logic [i2ssc_pkg::BcdW-1:0]     bcd_o
);
  import i2ssc_pkg::*;

  localparam int unsigned CntW = $clog2(NumW);
  localparam logic [CntW-1:0] CntLast = CntW'(NumW - 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] bin_q, bin_d;
  logic [BcdW-1:0] bcd_q, bcd_d;
  logic [BcdW-1:0] adj;

  // Every digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = number_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BcdW-2:0], bin_q[NumW-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = busy_q && (cnt_q == CntLast);
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

### hdl/integer_to_seven_segment_commands.sv
// The first write of each run is the scan limit; a run holds N = 2 to 9 writes in all.
// The bit-serial decimal conversion runs before the writes, and no new input is taken
// during the conversion or while the writes of the run are still being loaded.
// A new input is taken while the final write of the previous run still waits.
// Reset (rst_ni, asynchronous, active low) clears the sequencer and the output valid flag.
`default_nettype none

module integer_to_seven_segment_commands #(
  parameter int unsigned MAX_DIGITS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [i2ssc_pkg::NumW-1:0] number_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            write_kind_o,
  output logic [2:0]                      digit_position_o,
  output logic [7:0]                      write_data_o,
  output logic                            last_o
);
  import i2ssc_pkg::*;

  // Digits kept for the write phase.
  localparam int unsigned DigW = 4 * MAX_DIGITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic            err_q, err_d;
  logic [2:0]      lim_q, lim_d;
  logic [2:0]      pos_q, pos_d;
  logic            scan_q, scan_d;
  logic [DigW-1:0] dig_q, dig_d;

  logic       out_valid_q, out_valid_d;
  logic       kind_q, kind_d;
  logic [2:0] opos_q, opos_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;

  logic                in_take;
  logic                conv_done;
  logic [BcdW-1:0]     bcd;
  logic                err_c;
  logic [BcdIdxW-1:0]  hi_c;
  logic                load;
  logic                digit_last;

  // The converter is started by each input transaction; the item is held there.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_take    = in_valid_i && in_ready_o;

  i2ssc_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_take),
    .number_i (number_i),
    .done_o   (conv_done),
    .bcd_o    (bcd)
  );

  // A nonzero decimal digit at or above MAX_DIGITS means the value cannot be
  // shown. The highest nonzero digit sets the scan limit; zero gives digit 0.
  always_comb begin
    err_c = 1'b0;
    hi_c  = '0;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        hi_c = BcdIdxW'(i);
        if (i >= MAX_DIGITS) begin
          err_c = 1'b1;
        end
      end
    end
  end

  // The output register is refilled when empty or when its write is taken.
  assign load       = !out_valid_q || out_ready_i;
  assign digit_last = (pos_q == lim_q);

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    lim_d       = lim_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    dig_d       = dig_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    opos_d      = opos_q;
    data_d      = data_q;
    last_d      = last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // The conversion result is settled; latch the run's shape.
        err_d   = err_c;
        lim_d   = err_c ? ERR_LIMIT : hi_c[2:0];
        dig_d   = bcd[DigW-1:0];
        pos_d   = '0;
        scan_d  = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (scan_q) begin
            // The scan limit write always leads the run.
            kind_d = WK_SCAN;
            opos_d = '0;
            data_d = {5'd0, lim_q};
            last_d = 1'b0;
            scan_d = 1'b0;
          end else begin
            // Digit writes go out least significant first, one digit shifted out per write.
            kind_d = WK_DIGIT;
            opos_d = pos_q;
            data_d = err_q ? err_code(pos_q) : seg_code(dig_q[3:0]);
            last_d = digit_last;
            pos_d  = pos_q + 3'd1;
            dig_d  = dig_q >> 4;
            if (digit_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      scan_q      <= 1'b0;
      pos_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      scan_q      <= scan_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    lim_q  <= lim_d;
    dig_q  <= dig_d;
    kind_q <= kind_d;
    opos_q <= opos_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign write_kind_o     = kind_q;
  assign digit_position_o = opos_q;
  assign write_data_o     = data_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

### tb/integer_to_seven_segment_commands_tb.sv
`default_nettype none

module integer_to_seven_segment_commands_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import i2ssc_pkg::*;

  // One display-controller register write as the block presents it.
  typedef struct packed {
    logic       kind;
    logic [2:0] pos;
    logic [7:0] data;
    logic       last;
  } ctrl_write_t;

  // Largest value that still fits in eight decimal digits; anything above
  // it is shown as the "1rrE" error run.
  localparam logic [NumW-1:0] DisplayMax = 32'd99999999;
  localparam logic [2:0]      ErrPosE    = 3'd3;
  localparam int unsigned     RandomItems = 360;

  // Segment patterns of the decimal digits, bit 6 = a down to bit 0 = g.
  localparam logic [7:0] DigitSegments [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [NumW-1:0] number = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            write_kind;
  logic [2:0]      digit_position;
  logic [7:0]      write_data;
  logic            last;

  // Numbers still to be offered, and the writes predicted for the numbers
  // that the block has already taken, oldest first.
  logic [NumW-1:0] numbers_to_send [$];
  ctrl_write_t     expected_writes [$];

  int unsigned numbers_total = 0;
  int unsigned numbers_taken = 0;
  int unsigned fail_count    = 0;
  int unsigned send_wait     = 0;
  int unsigned recv_stall    = 0;

  // When set, the matching side runs without any pauses, so that the run
  // sees back-to-back stretches as well as gaps.
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  integer_to_seven_segment_commands DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .number_i        (number),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .write_kind_o    (write_kind),
    .digit_position_o(digit_position),
    .write_data_o    (write_data),
    .last_o          (last)
  );

  always #4 clk = ~clk;

  // Appends the writes that one number must produce: a scan limit write and
  // then one digit write per decimal digit, least significant digit first.
  // Numbers too wide for the display produce the fixed error run instead.
  function automatic void predict_display_writes(input logic [NumW-1:0] value);
    logic [NumW-1:0] rest;
    logic [3:0]      digits [10];
    int unsigned     count;
    rest = value;
    if (value > DisplayMax) begin
      expected_writes.push_back('{WK_SCAN, 3'd0, {5'd0, ERR_LIMIT}, 1'b0});
      expected_writes.push_back('{WK_DIGIT, ERR_POS_ONE, SEG_ONE, 1'b0});
      expected_writes.push_back('{WK_DIGIT, ERR_POS_R0, SEG_R, 1'b0});
      expected_writes.push_back('{WK_DIGIT, ERR_POS_R1, SEG_R, 1'b0});
      expected_writes.push_back('{WK_DIGIT, ErrPosE, SEG_E, 1'b1});
      return;
    end
    // Zero still yields one digit, hence the test on count as well.
    for (count = 0; count == 0 || rest != 0; count++) begin
      digits[count] = 4'(rest % 10);
      rest = rest / 10;
    end
    expected_writes.push_back('{WK_SCAN, 3'd0, 8'(count - 1), 1'b0});
    for (int unsigned k = 0; k < count; k++) begin
      expected_writes.push_back('{WK_DIGIT, 3'(k), DigitSegments[digits[k]],
                                  k == count - 1});
    end
  endfunction

  // Input side. After each transaction the driver draws a pause and then
  // offers the next number; valid is only lowered when a pause follows or no number
  // is left, so a back-to-back offer keeps valid high through the edge.
  always @(posedge clk or negedge rst_n) begin : send_numbers
    logic            nxt_valid;
    logic [NumW-1:0] nxt_number;
    int unsigned     nxt_wait;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      number    <= '0;
      send_wait <= 0;
    end else begin
      nxt_valid  = in_valid;
      nxt_number = number;
      nxt_wait   = send_wait;
      if (in_valid && in_ready) begin
        predict_display_writes(number);
        numbers_taken <= numbers_taken + 1;
        nxt_valid = 1'b0;
        if ($urandom_range(0, 15) == 0) begin
          send_quiet = !send_quiet;
        end
        nxt_wait = send_quiet ? 0 : $urandom_range(0, 17);
      end
      if (!nxt_valid) begin
        if (nxt_wait != 0) begin
          nxt_wait--;
        end else if (numbers_to_send.size() != 0) begin
          nxt_valid  = 1'b1;
          nxt_number = numbers_to_send.pop_front();
        end
      end
      in_valid  <= nxt_valid;
      number    <= nxt_number;
      send_wait <= nxt_wait;
    end
  end

  // Output side. Every accepted write is checked field by field against the
  // oldest prediction, and a fresh stall is drawn before the next one.
  always @(posedge clk or negedge rst_n) begin : check_writes
    ctrl_write_t want;
    int unsigned nxt_stall;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      nxt_stall = recv_stall;
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $error("write with no transaction behind it: kind %0d pos %0d data 0x%02h last %0d",
                 write_kind, digit_position, write_data, last);
          fail_count++;
        end else begin
          want = expected_writes.pop_front();
          if (write_kind !== want.kind) begin
            $error("write_kind: expected %0d, actual %0d", want.kind, write_kind);
            fail_count++;
          end
          if (digit_position !== want.pos) begin
            $error("digit_position: expected %0d, actual %0d", want.pos, digit_position);
            fail_count++;
          end
          if (write_data !== want.data) begin
            $error("write_data: expected 0x%02h, actual 0x%02h", want.data, write_data);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fail_count++;
          end
        end
        if ($urandom_range(0, 15) == 0) begin
          recv_quiet = !recv_quiet;
        end
        nxt_stall = recv_quiet ? 0 : $urandom_range(0, 17);
      end else if (nxt_stall != 0) begin
        nxt_stall--;
      end
      out_ready  <= (nxt_stall == 0);
      recv_stall <= nxt_stall;
    end
  end

  initial begin : run_test
    int unsigned pick;
    int unsigned digit_count;
    int unsigned floor_val;
    // Directed numbers: every single digit, zero among them, each digit
    // count, the widest value that still shows and the first one that does
    // not, the top of the input range and a lone top bit.
    numbers_to_send = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7,
                        32'd8, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4096,
                        32'd10001, 32'd987654, 32'd1000001, 32'd12345678,
                        32'd98765432, 32'd10000000, DisplayMax, DisplayMax + 1,
                        32'hFFFF_FFFF, 32'h8000_0000};
    // Random numbers: mostly values that fit, with an even spread of digit
    // counts, some around the display limit, and full-range values that
    // mostly land in the error run but exercise every input bit.
    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        digit_count = $urandom_range(1, 8);
        floor_val = 1;
        for (int j = 1; j < digit_count; j++) begin
          floor_val = floor_val * 10;
        end
        numbers_to_send.push_back($urandom_range(floor_val * 10 - 1,
                                                 digit_count == 1 ? 0 : floor_val));
      end else if (pick == 7) begin
        numbers_to_send.push_back(DisplayMax - 50 + $urandom_range(0, 100));
      end else begin
        numbers_to_send.push_back($urandom);
      end
    end
    numbers_total = numbers_to_send.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every number to be taken and every write to come out, then
    // give the block time to show any write it should not produce.
    while (numbers_taken < numbers_total || expected_writes.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);

    if (fail_count == 0 && expected_writes.size() == 0) begin
      $display("integer_to_seven_segment_commands test passed");
    end else begin
      $display("integer_to_seven_segment_commands test failed");
    end
    $finish;
  end

  // The slowest correct run ends well before this timeout gives up.
  initial begin : watchdog
    #4_000_000;
    $display("integer_to_seven_segment_commands test failed");
    $finish;
  end

endmodule

`default_nettype wire
